FILE: rtl/rcdm_pkg.sv
// shared types and constants of the route change dampening monitor
package rcdm_pkg;

    // ring of change timestamps
    localparam int WINDOW_DEPTH = 256;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int STAMP_W   = 32;
    localparam int PREFIX_W  = 16;
    localparam int PERCENT_W = 7;
    localparam int INTVL_W   = 16;
    localparam int RESTART_W = 8;
    localparam int FILL_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // percent * limit and count * 100
    localparam int PROD_W = PERCENT_W + PREFIX_W;
    localparam int LHS_W  = CNT_W + 7;
    localparam int CMP_W  = (LHS_W > PROD_W) ? LHS_W : PROD_W;

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);

    typedef enum logic [1:0] {
        MODE_CHANGE  = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_RESET   = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_MAX_PFX  = 3'd1,
        REG_PERCENT  = 3'd2,
        REG_INTERVAL = 3'd3,
        REG_RST_LIM  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_PRUNE,
        ST_CHECK
    } state_t;

    // settings seen by the sequencer
    typedef struct packed {
        logic                 enable;
        logic                 limit_set;
        logic [PROD_W-1:0]    threshold;
        logic [INTVL_W-1:0]   interval;
        logic [RESTART_W-1:0] restart_limit;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic [RESTART_W-1:0] restarts_seen;
        logic [FILL_W-1:0]    window_fill;
        logic                 start_interval_timer;
        logic                 start_restart_timer;
        logic                 start_reset_timer;
        logic                 suppressed;
        logic                 accepted;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

FILE: rtl/route_change_dampening_monitor.sv
// top level of the route change dampening monitor
//
// route change dampening monitor: each input word carries a mode in s_tuser
// (route change, interval tick, reset timer expiry, restart timer expiry) and a
// seconds timestamp in s_tdata; each word yields exactly one result word on the
// master side with the accepted and suppressed flags, the three timer requests,
// the window fill and the restart count. recorded route changes go into a
// 256-entry timestamp ring held in a single-port-read synchronous memory;
// entries older than interval_seconds are walked off the front one per cycle.
// an interval tick, a timer expiry or a route change that is not recorded goes
// from idle straight to the check state; a recorded route change goes through
// the push state, then, if older entries exist, the prune walk, which inspects
// at most WINDOW_DEPTH - 1 older ring entries, and then the check state.
// a finished result sits in an output register, so the next word is taken
// while it waits; a new result only stalls when that register is still full.
// no clearing pass is needed after reset. configuration registers are written
// through cfg_we/cfg_index/cfg_data and must only change while the block is idle
module route_change_dampening_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rcdm_pkg::STAMP_W-1:0]       s_tdata,   // [31:0] timestamp
    input  logic [1:0]                         s_tuser,   // [1:0] mode
    // master side
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] accepted, [1] suppressed, [2] start_reset_timer, [3] start_restart_timer,
    // [4] start_interval_timer, [13:5] window_fill, [21:14] restarts_seen, rest zero
    output logic [rcdm_pkg::OUT_DATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [rcdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcdm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    logic                           enable_reg;
    logic [rcdm_pkg::PREFIX_W-1:0]  max_prefix_reg;
    logic [rcdm_pkg::PERCENT_W-1:0] percent_reg;
    logic [rcdm_pkg::INTVL_W-1:0]   interval_reg;
    logic [rcdm_pkg::RESTART_W-1:0] restart_limit_reg;

    // trigger threshold percent * limit, registered off the multiplier
    logic [rcdm_pkg::PROD_W-1:0]    threshold_reg;

    rcdm_pkg::cfg_t    cfg;
    rcdm_pkg::result_t res;
    rcdm_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              res_valid;
    logic              res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            max_prefix_reg    <= '0;
            percent_reg       <= rcdm_pkg::PERCENT_W'(50);
            interval_reg      <= rcdm_pkg::INTVL_W'(60);
            restart_limit_reg <= rcdm_pkg::RESTART_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcdm_pkg::REG_ENABLE:   enable_reg        <= cfg_data[0];
                rcdm_pkg::REG_MAX_PFX:  max_prefix_reg    <= cfg_data;
                rcdm_pkg::REG_PERCENT:  percent_reg       <= cfg_data[rcdm_pkg::PERCENT_W-1:0];
                rcdm_pkg::REG_INTERVAL: interval_reg      <= cfg_data;
                rcdm_pkg::REG_RST_LIM:  restart_limit_reg <= cfg_data[rcdm_pkg::RESTART_W-1:0];
                default:                ; // unknown index, write dropped
            endcase
        end
    end

    // config must only change while idle, which the block does not enforce, so a registered product is current
    always_ff @(posedge clk)
    begin
        threshold_reg <= rcdm_pkg::PROD_W'(percent_reg * max_prefix_reg);
    end

    assign cfg.enable        = enable_reg;
    assign cfg.limit_set     = (max_prefix_reg != '0);
    assign cfg.threshold     = threshold_reg;
    assign cfg.interval      = interval_reg;
    assign cfg.restart_limit = restart_limit_reg;

    rcdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (rcdm_pkg::mode_t'(s_tuser)),
        .in_stamp  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register, free when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rcdm_pkg::OUT_DATA_W'(out_reg);

endmodule

FILE: rtl/rcdm_ring_mem.sv
// timestamp ring storage, one write and one registered read port
module rcdm_ring_mem (
    input  logic                               clk,
    input  logic                               we,
    input  logic [rcdm_pkg::ADDR_W-1:0]        waddr,
    input  logic [rcdm_pkg::STAMP_W-1:0]       wdata,
    input  logic [rcdm_pkg::ADDR_W-1:0]        raddr,
    output logic [rcdm_pkg::STAMP_W-1:0]       rdata
);

    logic [rcdm_pkg::STAMP_W-1:0] mem [rcdm_pkg::WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/rcdm_ctrl.sv
// sequencer: ring push and prune walk, trigger check and step state
module rcdm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rcdm_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rcdm_pkg::mode_t                in_mode,
    input  logic [rcdm_pkg::STAMP_W-1:0]   in_stamp,
    output logic                           res_valid,
    input  logic                           res_ready,
    output rcdm_pkg::result_t              res
);

    rcdm_pkg::state_t state_reg, state_next;
    rcdm_pkg::mode_t  mode_reg, mode_next;
    logic [rcdm_pkg::STAMP_W-1:0]   stamp_reg, stamp_next;
    logic                           accepted_reg, accepted_next;
    logic [rcdm_pkg::ADDR_W-1:0]    head_reg, head_next;
    logic [rcdm_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           supp_reg, supp_next;
    logic [rcdm_pkg::RESTART_W-1:0] rc_reg, rc_next;
    logic [rcdm_pkg::PREFIX_W-1:0]  prefix_reg, prefix_next;

    logic                           mem_we;
    logic [rcdm_pkg::ADDR_W-1:0]    mem_waddr;
    logic [rcdm_pkg::ADDR_W-1:0]    mem_raddr;
    logic [rcdm_pkg::STAMP_W-1:0]   mem_rdata;

    logic                           full;
    logic [rcdm_pkg::ADDR_W-1:0]    head_inc;
    logic [rcdm_pkg::ADDR_W-1:0]    push_head;
    logic [rcdm_pkg::CNT_W-1:0]     push_count;
    logic [rcdm_pkg::ADDR_W:0]      tail_sum;
    logic [rcdm_pkg::ADDR_W-1:0]    tail_addr;
    logic [rcdm_pkg::STAMP_W-1:0]   age;
    logic                           too_old;
    logic [rcdm_pkg::CMP_W-1:0]     lhs;
    logic                           trig;
    logic                           reset_req, restart_req, interval_req;

    rcdm_ring_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (stamp_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ring pointer arithmetic
    assign full      = (count_reg == rcdm_pkg::DEPTH_CNT);
    assign head_inc  = (head_reg == rcdm_pkg::LAST_ADDR) ? '0 : head_reg + 1'b1;
    assign push_head = full ? head_inc : head_reg;
    assign push_count = full ? count_reg - 1'b1 : count_reg;
    assign tail_sum  = {1'b0, push_head} + {1'b0, push_count[rcdm_pkg::ADDR_W-1:0]};
    assign tail_addr = (tail_sum >= (rcdm_pkg::ADDR_W+1)'(rcdm_pkg::WINDOW_DEPTH))
                     ? rcdm_pkg::ADDR_W'(tail_sum - (rcdm_pkg::ADDR_W+1)'(rcdm_pkg::WINDOW_DEPTH))
                     : tail_sum[rcdm_pkg::ADDR_W-1:0];

    assign age     = stamp_reg - mem_rdata;
    assign too_old = age > {{(rcdm_pkg::STAMP_W-rcdm_pkg::INTVL_W){1'b0}}, cfg.interval};

    // count * 100 as shifts
    assign lhs  = (rcdm_pkg::CMP_W'(count_reg) << 6) + (rcdm_pkg::CMP_W'(count_reg) << 5)
                + (rcdm_pkg::CMP_W'(count_reg) << 2);
    assign trig = cfg.limit_set && (lhs >= rcdm_pkg::CMP_W'(cfg.threshold)) && !supp_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        stamp_next    = stamp_reg;
        accepted_next = accepted_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        supp_next     = supp_reg;
        rc_next       = rc_reg;
        prefix_next   = prefix_reg;
        mem_we        = 1'b0;
        mem_waddr     = tail_addr;
        mem_raddr     = head_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        reset_req     = 1'b0;
        restart_req   = 1'b0;
        interval_req  = 1'b0;

        unique case (state_reg)
            rcdm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next     = in_mode;
                    stamp_next    = in_stamp;
                    accepted_next = (in_mode == rcdm_pkg::MODE_CHANGE)
                                  && (!cfg.enable || !supp_reg);
                    if (in_mode == rcdm_pkg::MODE_CHANGE && cfg.enable)
                    begin
                        state_next = rcdm_pkg::ST_PUSH;
                    end
                    else
                    begin
                        state_next = rcdm_pkg::ST_CHECK;
                    end
                end
            end

            rcdm_pkg::ST_PUSH:
            begin
                // drop oldest when full, append, start reading the front
                mem_we     = 1'b1;
                head_next  = push_head;
                count_next = push_count + 1'b1;
                mem_raddr  = push_head;
                if (push_count != '0)
                begin
                    state_next = rcdm_pkg::ST_PRUNE;
                end
                else
                begin
                    state_next = rcdm_pkg::ST_CHECK;
                end
            end

            rcdm_pkg::ST_PRUNE:
            begin
                // front entry data is valid here; newest entry never ages out
                if (too_old)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    mem_raddr  = head_inc;
                    if (count_reg > rcdm_pkg::CNT_W'(2))
                    begin
                        state_next = rcdm_pkg::ST_PRUNE;
                    end
                    else
                    begin
                        state_next = rcdm_pkg::ST_CHECK;
                    end
                end
                else
                begin
                    state_next = rcdm_pkg::ST_CHECK;
                end
            end

            rcdm_pkg::ST_CHECK:
            begin
                res_valid = 1'b1;
                case (mode_reg)
                    rcdm_pkg::MODE_CHANGE:
                    begin
                        if (cfg.limit_set && prefix_reg != '1)
                        begin
                            prefix_next = prefix_reg + 1'b1;
                        end
                        if (trig)
                        begin
                            supp_next = 1'b1;
                            rc_next   = (rc_reg != '1) ? rc_reg + 1'b1 : rc_reg;
                            reset_req = 1'b1;
                        end
                    end
                    rcdm_pkg::MODE_TICK:
                    begin
                        if (cfg.enable)
                        begin
                            interval_req = 1'b1;
                            if (trig)
                            begin
                                supp_next = 1'b1;
                                rc_next   = (rc_reg != '1) ? rc_reg + 1'b1 : rc_reg;
                                reset_req = 1'b1;
                            end
                        end
                    end
                    rcdm_pkg::MODE_RESET:
                    begin
                        if (supp_reg)
                        begin
                            supp_next   = 1'b0;
                            head_next   = '0;
                            count_next  = '0;
                            prefix_next = '0;
                            restart_req = rc_reg < cfg.restart_limit;
                        end
                    end
                    default:
                    begin
                        rc_next     = '0;
                        prefix_next = '0;
                        head_next   = '0;
                        count_next  = '0;
                    end
                endcase
                if (res_ready)
                begin
                    state_next = rcdm_pkg::ST_IDLE;
                end
                else
                begin
                    // hold everything until the output slot frees up
                    head_next   = head_reg;
                    count_next  = count_reg;
                    supp_next   = supp_reg;
                    rc_next     = rc_reg;
                    prefix_next = prefix_reg;
                end
            end

            default:
            begin
                state_next = rcdm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.accepted             = accepted_reg;
        res.suppressed           = supp_next;
        res.start_reset_timer    = reset_req;
        res.start_restart_timer  = restart_req;
        res.start_interval_timer = interval_req;
        res.window_fill          = rcdm_pkg::FILL_W'(count_next);
        res.restarts_seen        = rc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rcdm_pkg::ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            supp_reg   <= 1'b0;
            rc_reg     <= '0;
            prefix_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            supp_reg   <= supp_next;
            rc_reg     <= rc_next;
            prefix_reg <= prefix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        stamp_reg    <= stamp_next;
        accepted_reg <= accepted_next;
    end

endmodule
